[design/foq_pkg.sv]
`timescale 1ns / 1ps
// Shared types for the frequency-ordered queue: entry layout, command and
// status codes, and the controller/datapath command and status structs.
package foq_pkg;

   typedef enum logic [1:0] {
      CMD_COUNT  = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_GIVEN = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_FULL  = 2'd3
   } stat_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SEARCH,
      S_SINK,
      S_LEAF,
      S_POP
   } state_type;

   typedef enum logic [1:0] {
      POS_HOLD,
      POS_ZERO,
      POS_INC
   } pos_op_type;

   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_REQ,
      CUR_BUMP
   } cur_op_type;

   typedef enum logic [1:0] {
      WR_RDATA,
      WR_CUR,
      WR_LEAF
   } wr_src_type;

   typedef struct packed {
      logic        is_node;
      logic [8:0]  key;
      logic [31:0] freq;
   } entry_type;

   typedef struct packed {
      logic       capture;
      pos_op_type pos_op;
      logic       rd_en;
      logic       rd_off;
      logic       head_dec;
      logic       head_inc;
      logic       cnt_inc;
      logic       cnt_dec;
      cur_op_type cur_op;
      logic       wr_en;
      wr_src_type wr_src;
      logic       rsp_load;
      logic       rsp_pop;
      stat_type   rsp_stat;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    cnt_zero;
      logic    full;
      logic    last;
      logic    match;
      logic    less;
      logic    rsp_busy;
   } sts_type;

endpackage

[design/foq_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine for the frequency-ordered queue.
// Uses foq_pkg; drives the datapath through ctl_type, reads sts_type.
module foq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  foq_pkg::sts_type sts,
   output foq_pkg::ctl_type ctl
);

   foq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= foq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         foq_pkg::S_IDLE: begin
            if (req_valid && !sts.rsp_busy) state_in = foq_pkg::S_DECODE;
         end
         foq_pkg::S_DECODE: begin
            unique case (sts.cmd)
               foq_pkg::CMD_COUNT:
                  state_in = sts.cnt_zero ? foq_pkg::S_LEAF : foq_pkg::S_SEARCH;
               foq_pkg::CMD_INSERT:
                  state_in = sts.full ? foq_pkg::S_IDLE : foq_pkg::S_SINK;
               foq_pkg::CMD_REMOVE:
                  state_in = sts.cnt_zero ? foq_pkg::S_IDLE : foq_pkg::S_POP;
               default: state_in = foq_pkg::S_IDLE;
            endcase
         end
         foq_pkg::S_SEARCH: begin
            if (sts.match) state_in = foq_pkg::S_SINK;
            else if (sts.last) state_in = sts.full ? foq_pkg::S_IDLE : foq_pkg::S_LEAF;
         end
         foq_pkg::S_SINK: begin
            if (sts.last || !sts.less) state_in = foq_pkg::S_IDLE;
         end
         foq_pkg::S_LEAF: state_in = foq_pkg::S_IDLE;
         foq_pkg::S_POP:  state_in = foq_pkg::S_IDLE;
         default:         state_in = foq_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      ctl.pos_op   = foq_pkg::POS_HOLD;
      ctl.cur_op   = foq_pkg::CUR_HOLD;
      ctl.wr_src   = foq_pkg::WR_CUR;
      ctl.rsp_stat = foq_pkg::STAT_DONE;
      req_ready    = 1'b0;
      unique case (state_ff)
         foq_pkg::S_IDLE: begin
            req_ready   = !sts.rsp_busy;
            ctl.capture = req_valid && !sts.rsp_busy;
         end
         foq_pkg::S_DECODE: begin
            unique case (sts.cmd)
               foq_pkg::CMD_COUNT: begin
                  ctl.pos_op = foq_pkg::POS_ZERO;
                  if (sts.cnt_zero) begin
                     ctl.head_dec = 1'b1;
                     ctl.cnt_inc  = 1'b1;
                  end else begin
                     ctl.rd_en = 1'b1;
                  end
               end
               foq_pkg::CMD_INSERT: begin
                  if (sts.full) begin
                     ctl.rsp_load = 1'b1;
                     ctl.rsp_stat = foq_pkg::STAT_FULL;
                  end else begin
                     ctl.head_dec = 1'b1;
                     ctl.cnt_inc  = 1'b1;
                     ctl.pos_op   = foq_pkg::POS_ZERO;
                     ctl.cur_op   = foq_pkg::CUR_REQ;
                     ctl.rd_en    = 1'b1;
                     ctl.rd_off   = 1'b1;
                  end
               end
               foq_pkg::CMD_REMOVE: begin
                  if (sts.cnt_zero) begin
                     ctl.rsp_load = 1'b1;
                     ctl.rsp_stat = foq_pkg::STAT_EMPTY;
                  end else begin
                     ctl.pos_op = foq_pkg::POS_ZERO;
                     ctl.rd_en  = 1'b1;
                  end
               end
               default: ctl.rsp_load = 1'b1;
            endcase
         end
         foq_pkg::S_SEARCH: begin
            if (sts.match) begin
               ctl.cur_op = foq_pkg::CUR_BUMP;
               ctl.rd_en  = 1'b1;
               ctl.rd_off = 1'b1;
            end else if (sts.last) begin
               if (sts.full) begin
                  ctl.rsp_load = 1'b1;
                  ctl.rsp_stat = foq_pkg::STAT_FULL;
               end else begin
                  ctl.head_dec = 1'b1;
                  ctl.cnt_inc  = 1'b1;
                  ctl.pos_op   = foq_pkg::POS_ZERO;
               end
            end else begin
               ctl.pos_op = foq_pkg::POS_INC;
               ctl.rd_en  = 1'b1;
            end
         end
         foq_pkg::S_SINK: begin
            ctl.wr_en = 1'b1;
            if (!sts.last && sts.less) begin
               ctl.wr_src = foq_pkg::WR_RDATA;
               ctl.pos_op = foq_pkg::POS_INC;
               ctl.rd_en  = 1'b1;
               ctl.rd_off = 1'b1;
            end else begin
               ctl.rsp_load = 1'b1;
            end
         end
         foq_pkg::S_LEAF: begin
            ctl.wr_en    = 1'b1;
            ctl.wr_src   = foq_pkg::WR_LEAF;
            ctl.rsp_load = 1'b1;
         end
         foq_pkg::S_POP: begin
            ctl.rsp_load = 1'b1;
            ctl.rsp_pop  = 1'b1;
            ctl.rsp_stat = foq_pkg::STAT_GIVEN;
            ctl.head_inc = 1'b1;
            ctl.cnt_dec  = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

[design/foq_dp.sv]
`timescale 1ns / 1ps
// Datapath for the frequency-ordered queue: circular entry memory, head,
// count and position registers, moving-entry register and result register.
module foq_dp #(
   parameter int ENTRIES = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  foq_pkg::ctl_type ctl,
   output foq_pkg::sts_type sts,
   input  logic [1:0]       req_cmd,
   input  logic [7:0]       req_symbol,
   input  logic [8:0]       req_node_ref,
   input  logic [31:0]      req_freq_in,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic             rsp_out_is_node,
   output logic [7:0]       rsp_out_symbol,
   output logic [8:0]       rsp_out_node_ref,
   output logic [31:0]      rsp_out_freq
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int SW = CW + 1;
   localparam logic [SW-1:0] ESUM = SW'(ENTRIES);
   localparam logic [IW-1:0] ELAST = IW'(ENTRIES - 1);
   localparam logic [CW-1:0] EFULL = CW'(ENTRIES);

   foq_pkg::entry_type mem [ENTRIES];
   foq_pkg::entry_type rdata_ff, cur_ff, cur_in, wdata;
   foq_pkg::cmd_type   cmd_ff;
   logic [7:0]         sym_ff;
   logic [8:0]         ref_ff;
   logic [31:0]        fin_ff;
   logic [IW-1:0]      head_ff, head_in, rd_addr, wr_addr;
   logic [CW-1:0]      cnt_ff, cnt_in, pos_ff, pos_in;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic               rsp_is_node_ff;
   logic [7:0]         rsp_symbol_ff;
   logic [8:0]         rsp_ref_ff;
   logic [31:0]        rsp_freq_ff;

   function automatic logic [IW-1:0] wrap(input logic [SW-1:0] s);
      logic [SW-1:0] r;
      r = (s >= ESUM) ? s - ESUM : s;
      return r[IW-1:0];
   endfunction

   always_comb begin
      head_in = head_ff;
      if (ctl.head_dec) head_in = (head_ff == '0) ? ELAST : head_ff - 1'b1;
      else if (ctl.head_inc) head_in = (head_ff == ELAST) ? '0 : head_ff + 1'b1;
      cnt_in = cnt_ff;
      if (ctl.cnt_inc) cnt_in = cnt_ff + 1'b1;
      else if (ctl.cnt_dec) cnt_in = cnt_ff - 1'b1;
      case (ctl.pos_op)
         foq_pkg::POS_ZERO: pos_in = '0;
         foq_pkg::POS_INC:  pos_in = pos_ff + 1'b1;
         default:           pos_in = pos_ff;
      endcase
      cur_in = cur_ff;
      case (ctl.cur_op)
         foq_pkg::CUR_REQ: cur_in = '{is_node: 1'b1, key: ref_ff, freq: fin_ff};
         foq_pkg::CUR_BUMP: begin
            cur_in = rdata_ff;
            if (rdata_ff.freq != '1) cur_in.freq = rdata_ff.freq + 1'b1;
         end
         default: ;
      endcase
      case (ctl.wr_src)
         foq_pkg::WR_RDATA: wdata = rdata_ff;
         foq_pkg::WR_LEAF:  wdata = '{is_node: 1'b0, key: {1'b0, sym_ff}, freq: 32'd1};
         default:           wdata = cur_ff;
      endcase
      rd_addr = wrap(SW'(head_in) + SW'(pos_in) + SW'(ctl.rd_off));
      wr_addr = wrap(SW'(head_ff) + SW'(pos_ff));
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) mem[wr_addr] <= wdata;
      if (ctl.rd_en) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= foq_pkg::CMD_NONE;
      end else begin
         head_ff <= head_in;
         cnt_ff  <= cnt_in;
         pos_ff  <= pos_in;
         if (ctl.capture) cmd_ff <= foq_pkg::cmd_type'(req_cmd);
         if (ctl.rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (ctl.capture) begin
         sym_ff <= req_symbol;
         ref_ff <= req_node_ref;
         fin_ff <= req_freq_in;
      end
      if (ctl.rsp_load) begin
         rsp_status_ff  <= ctl.rsp_stat;
         rsp_is_node_ff <= ctl.rsp_pop && rdata_ff.is_node;
         rsp_symbol_ff  <= (ctl.rsp_pop && !rdata_ff.is_node) ? rdata_ff.key[7:0] : 8'd0;
         rsp_ref_ff     <= (ctl.rsp_pop && rdata_ff.is_node) ? rdata_ff.key : 9'd0;
         rsp_freq_ff    <= ctl.rsp_pop ? rdata_ff.freq : 32'd0;
      end
   end

   assign sts.cmd      = cmd_ff;
   assign sts.cnt_zero = (cnt_ff == '0);
   assign sts.full     = (cnt_ff == EFULL);
   assign sts.last     = ((pos_ff + 1'b1) >= cnt_ff);
   assign sts.match    = !rdata_ff.is_node && (rdata_ff.key == {1'b0, sym_ff});
   assign sts.less     = (rdata_ff.freq < cur_ff.freq);
   assign sts.rsp_busy = rsp_valid_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_is_node  = rsp_is_node_ff;
   assign rsp_out_symbol   = rsp_symbol_ff;
   assign rsp_out_node_ref = rsp_ref_ff;
   assign rsp_out_freq     = rsp_freq_ff;

endmodule

[design/frequency_ordered_queue_core.sv]
`timescale 1ns / 1ps
// Frequency-ordered queue top level: controller plus datapath.
// Remove returns the head entry; remove on an empty table, unused commands and insert
// on a full table answer at decode; count searches for the symbol, then a hit or insert
// sinks the entry past lower-frequency ones. One word at a time; the next word is taken
// in the cycle after the result is taken; the entry walk over the single-port-read memory
// sets the rate. Reset clears head, count and control at once; memory is not swept.
module frequency_ordered_queue_core #(
   parameter int ENTRIES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_symbol,
   input  logic [8:0]  req_node_ref,
   input  logic [31:0] req_freq_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_out_is_node,
   output logic [7:0]  rsp_out_symbol,
   output logic [8:0]  rsp_out_node_ref,
   output logic [31:0] rsp_out_freq
);

   foq_pkg::ctl_type ctl;
   foq_pkg::sts_type sts;

   foq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   foq_dp #(.ENTRIES(ENTRIES)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .sts              (sts),
      .req_cmd          (req_cmd),
      .req_symbol       (req_symbol),
      .req_node_ref     (req_node_ref),
      .req_freq_in      (req_freq_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_out_is_node  (rsp_out_is_node),
      .rsp_out_symbol   (rsp_out_symbol),
      .rsp_out_node_ref (rsp_out_node_ref),
      .rsp_out_freq     (rsp_out_freq)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted word did not make the block busy");

   a_ready_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("ready while a result is pending");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a word in work");

   a_given_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != foq_pkg::STAT_GIVEN |->
         !rsp_out_is_node && rsp_out_freq == 32'd0)
      else $error("removed-entry fields set without a removal");

endmodule
